### hw/rtl/rotl_pkg.sv
package rotl_pkg;

  localparam int TIME_W   = 63;
  localparam int LIMIT_W  = 40;
  localparam int MASK_W   = 4;
  localparam int CFG_IDX_W = 2;
  localparam int DEF_CHANNELS = 4;

  localparam logic [CFG_IDX_W-1:0] REG_ON_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE  = 2'd2;

  localparam logic [LIMIT_W-1:0] ON_LIMIT_RST = 40'd1215040500;
  localparam logic [LIMIT_W-1:0] COOLDOWN_RST = 40'd1215040500;
  localparam logic [LIMIT_W-1:0] RELEASE_RST  = 40'd4090500;

  typedef struct packed {
    logic [LIMIT_W-1:0] on_limit;
    logic [LIMIT_W-1:0] cooldown;
    logic [LIMIT_W-1:0] release_lim;
  } cfg_t;

  typedef struct packed {
    logic blocked;
    logic forced;
  } chan_stat_t;

  // The elapsed time is taken modulo 2^64 as signed; since both stamps are
  // below 2^63, bit 63 of the difference is set exactly when time went back.
  function automatic logic reached(input logic [TIME_W-1:0] now,
                                   input logic [TIME_W-1:0] start,
                                   input logic [LIMIT_W-1:0] limit);
    logic [TIME_W:0] diff;
    diff = {1'b0, now} - {1'b0, start};
    return !diff[TIME_W] && (diff >= {{(TIME_W + 1 - LIMIT_W){1'b0}}, limit});
  endfunction

endpackage

### hw/rtl/rotl_cfg.sv
module rotl_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  input  logic [rotl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rotl_pkg::LIMIT_W-1:0]   cfg_data,
  output logic                           cfg_ready,
  output rotl_pkg::cfg_t                 cfg
);
  import rotl_pkg::*;

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.on_limit    <= ON_LIMIT_RST;
      cfg_r.cooldown    <= COOLDOWN_RST;
      cfg_r.release_lim <= RELEASE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ON_LIMIT: cfg_r.on_limit    <= cfg_data;
        REG_COOLDOWN: cfg_r.cooldown    <= cfg_data;
        REG_RELEASE:  cfg_r.release_lim <= cfg_data;
        default: begin
          // Unknown indexes are ignored.
        end
      endcase
    end
  end

endmodule

### hw/rtl/rotl_chan.sv
module rotl_chan (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        upd,
  input  logic [rotl_pkg::TIME_W-1:0] now,
  input  logic                        motor,
  input  rotl_pkg::cfg_t              cfg,
  output rotl_pkg::chan_stat_t        stat
);
  import rotl_pkg::*;

  logic              run_active_r, run_active_nxt;
  logic              forced_r, forced_nxt;
  logic              rel_pend_r, rel_pend_nxt;
  logic [TIME_W-1:0] run_start_r, run_start_nxt;
  logic [TIME_W-1:0] forced_start_r, forced_start_nxt;
  logic [TIME_W-1:0] rel_start_r, rel_start_nxt;

  always_comb begin
    run_active_nxt   = run_active_r;
    forced_nxt       = forced_r;
    rel_pend_nxt     = rel_pend_r;
    run_start_nxt    = run_start_r;
    forced_start_nxt = forced_start_r;
    rel_start_nxt    = rel_start_r;
    if (!forced_r) begin
      if (motor) begin
        run_active_nxt = 1'b1;
        if (!run_active_r) begin
          run_start_nxt = now;
        end
        if (reached(now, run_start_nxt, cfg.on_limit)) begin
          forced_nxt       = 1'b1;
          forced_start_nxt = now;
        end
        rel_pend_nxt = 1'b0;
      end else if (run_active_r) begin
        rel_pend_nxt = 1'b1;
        if (!rel_pend_r) begin
          rel_start_nxt = now;
        end
        if (reached(now, rel_start_nxt, cfg.release_lim)) begin
          rel_pend_nxt   = 1'b0;
          run_active_nxt = 1'b0;
        end
      end
    end else if (reached(now, forced_start_r, cfg.cooldown)) begin
      forced_nxt     = 1'b0;
      run_active_nxt = 1'b0;
    end
  end

  // A channel that was forced at the start of the step stays blocked for it.
  assign stat.blocked = forced_r;
  assign stat.forced  = forced_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_active_r <= 1'b0;
      forced_r     <= 1'b0;
      rel_pend_r   <= 1'b0;
    end else if (upd) begin
      run_active_r <= run_active_nxt;
      forced_r     <= forced_nxt;
      rel_pend_r   <= rel_pend_nxt;
    end
  end

  // The time stamps are only read while their flag is set, so they need no reset.
  always_ff @(posedge clk) begin
    if (upd) begin
      run_start_r    <= run_start_nxt;
      forced_start_r <= forced_start_nxt;
      rel_start_r    <= rel_start_nxt;
    end
  end

endmodule

### hw/rtl/rumble_on_time_limiter.sv
// Rumble on-time limiter.
//
// Requests arrive on the in_ channel (valid/stall): a timer stamp, a motor-on
// mask and the busy and paused flags. Each request yields exactly one result
// on the out_ channel: the block mask and the forced-cooldown mask.
// Limits are set through the cfg_ write port (valid/ready, always ready);
// they should only be changed while no request is in flight.
//
// A request accepted into the input register moves on when the output
// register is free: the per-channel subtract-and-compare then updates the
// channel state and the result is stored in the output register, where
// out_valid rises. One request is taken every cycle while the receiver does
// not stall; the rate is set by the single channel update stage.
//
// Reset clears all channel state and loads the default limits. When the
// receiver stalls, the output register holds its result and the input
// register keeps the next request, so in_stall rises only when both are full.
module rumble_on_time_limiter #(
  parameter int CHANNELS = rotl_pkg::DEF_CHANNELS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [rotl_pkg::TIME_W-1:0]    in_now_ticks,
  input  logic [rotl_pkg::MASK_W-1:0]    in_motor_on,
  input  logic                           in_system_busy,
  input  logic                           in_system_paused,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [rotl_pkg::MASK_W-1:0]    out_block_mask,
  output logic [rotl_pkg::MASK_W-1:0]    out_forced_mask,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rotl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rotl_pkg::LIMIT_W-1:0]   cfg_data
);
  import rotl_pkg::*;

  localparam int NCH_OUT = (CHANNELS < MASK_W) ? CHANNELS : MASK_W;
  localparam logic [MASK_W-1:0] FULL_MASK = {MASK_W{1'b1}} >> (MASK_W - NCH_OUT);

  cfg_t cfg;

  // Input register.
  logic              s1_valid_r;
  logic [TIME_W-1:0] s1_now_r;
  logic [MASK_W-1:0] s1_motor_r;
  logic              s1_hold_r;

  // Output register.
  logic              out_valid_r;
  logic [MASK_W-1:0] out_block_r;
  logic [MASK_W-1:0] out_forced_r;

  logic adv;
  logic in_take;

  logic [CHANNELS-1:0] chan_blk;
  logic [CHANNELS-1:0] chan_frc;
  logic [MASK_W-1:0]   blk_mask;
  logic [MASK_W-1:0]   frc_mask;

  rotl_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .cfg       (cfg)
  );

  // The stage moves on when the output register is empty or being emptied.
  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;
  assign in_take  = in_valid && !in_stall;

  // Channels past the motor field see their motor as off; output bits past
  // the mask width are dropped and missing channels read as zero.
  for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
    logic       motor_bit;
    chan_stat_t stat;

    if (i < MASK_W) begin : g_in
      assign motor_bit = s1_motor_r[i];
    end else begin : g_none
      assign motor_bit = 1'b0;
    end

    rotl_chan u_chan (
      .clk   (clk),
      .rst_n (rst_n),
      .upd   (adv),
      .now   (s1_now_r),
      .motor (motor_bit),
      .cfg   (cfg),
      .stat  (stat)
    );

    assign chan_blk[i] = stat.blocked || s1_hold_r;
    assign chan_frc[i] = stat.forced;
  end

  for (genvar j = 0; j < MASK_W; j++) begin : g_out
    if (j < CHANNELS) begin : g_used
      assign blk_mask[j] = chan_blk[j];
      assign frc_mask[j] = chan_frc[j];
    end else begin : g_zero
      assign blk_mask[j] = 1'b0;
      assign frc_mask[j] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_now_r   <= in_now_ticks;
      s1_motor_r <= in_motor_on;
      s1_hold_r  <= in_system_busy || in_system_paused;
    end
    if (adv) begin
      out_block_r  <= blk_mask;
      out_forced_r <= frc_mask;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_block_mask  = out_block_r;
  assign out_forced_mask = out_forced_r;

  // A request that leaves the input register always lands in the output register.
  a_adv_lands: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("advanced request did not reach the output register");

  // The input side is only held off while the input register is occupied.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled without a full pipeline");

  // While the system is busy or paused every channel is blocked.
  a_hold_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_hold_r) |=> (out_block_mask == FULL_MASK))
    else $error("busy or paused request did not block all channels");

  // A stalled result is never overwritten by the next request.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !adv)
    else $error("stalled result overwritten");

endmodule
